>>> rtl/core/tsfs_pkg.sv
// ----------------------------------------------------------------------------
// TLV stream field search: shared types
// Item, result and internal token formats, status codes and register indexes.
// ----------------------------------------------------------------------------
package tsfs_pkg;

	typedef enum logic [1:0] {
		ST_FOUND  = 2'd0,
		ST_ABSENT = 2'd1,
		ST_TRUNC  = 2'd2,
		ST_BADLEN = 2'd3
	} status_t;

	typedef enum logic {
		REG_TARGET_TYPE   = 1'b0,
		REG_VALUE_IS_WIDE = 1'b1
	} reg_idx_t;

	localparam int unsigned CFG_W = 16;

	localparam logic [15:0] LEN_NARROW = 16'd4;
	localparam logic [15:0] LEN_WIDE   = 16'd8;

	typedef struct packed {
		logic [7:0] data_byte;
		logic       is_last;
	} in_item_t;

	typedef struct packed {
		status_t     status;
		logic [63:0] value;
	} out_item_t;

	// One classified byte passed from the parser to the value assembler.
	typedef struct packed {
		logic [7:0] data_byte;
		logic       shift_en;
		logic       clear_en;
		logic       is_last;
		status_t    status;
	} token_t;

endpackage

>>> rtl/core/tsfs_front.sv
// ----------------------------------------------------------------------------
// TLV stream field search: header parser
// Walks the element headers, counts value bytes, decides the outcome of the
// first matching element and emits one token per accepted byte.
// ----------------------------------------------------------------------------
module tsfs_front (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cfg_wr_en,
	input  tsfs_pkg::reg_idx_t cfg_idx,
	input  logic [tsfs_pkg::CFG_W-1:0] cfg_data,
	input  logic              take,
	input  tsfs_pkg::in_item_t item,
	output tsfs_pkg::token_t  tok
);
	import tsfs_pkg::*;

	logic [15:0] target_type_q;
	logic        value_is_wide_q;

	logic [1:0]  phase_q, n_phase;
	logic [15:0] type_q, n_type;
	logic [15:0] len_q, n_len;
	logic [15:0] left_q, n_left;
	logic        in_value_q, n_in_value;
	logic        match_q, n_match;
	logic        decided_q, n_decided;
	status_t     dstat_q, n_dstat;
	logic [15:0] len_full;
	logic [15:0] want;
	logic        shift_en, clear_en;
	status_t     status;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			target_type_q   <= '0;
			value_is_wide_q <= 1'b0;
		end else if (cfg_wr_en) begin
			unique case (cfg_idx)
				REG_TARGET_TYPE:   target_type_q   <= cfg_data;
				REG_VALUE_IS_WIDE: value_is_wide_q <= cfg_data[0];
				default: ;
			endcase
		end
	end

	assign len_full = {len_q[7:0], item.data_byte};
	assign want     = value_is_wide_q ? LEN_WIDE : LEN_NARROW;

	always_comb begin
		n_phase    = phase_q;
		n_type     = type_q;
		n_len      = len_q;
		n_left     = left_q;
		n_in_value = in_value_q;
		n_match    = match_q;
		n_decided  = decided_q;
		n_dstat    = dstat_q;
		shift_en   = 1'b0;
		clear_en   = 1'b0;
		if (!decided_q) begin
			if (in_value_q) begin
				n_left = left_q - 16'd1;
				if (match_q && dstat_q == ST_FOUND) begin
					shift_en = 1'b1;
				end
				if (left_q == 16'd1) begin
					n_in_value = 1'b0;
					if (match_q) begin
						n_match   = 1'b0;
						n_decided = 1'b1;
					end
				end
			end else begin
				if (!phase_q[1]) begin
					n_type = {type_q[7:0], item.data_byte};
				end else begin
					n_len = len_full;
				end
				if (phase_q != 2'd3) begin
					n_phase = phase_q + 2'd1;
				end else begin
					n_phase = 2'd0;
					if (type_q == target_type_q) begin
						n_dstat  = (len_full == want) ? ST_FOUND : ST_BADLEN;
						clear_en = 1'b1;
						if (len_full == 16'd0) begin
							n_decided = 1'b1;
						end else begin
							n_match = 1'b1;
						end
					end
					if (len_full != 16'd0) begin
						n_in_value = 1'b1;
						n_left     = len_full;
					end
				end
			end
		end
		if (n_decided) begin
			status = n_dstat;
		end else if (n_in_value) begin
			status = ST_TRUNC;
		end else begin
			status = ST_ABSENT;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q    <= '0;
			type_q     <= '0;
			len_q      <= '0;
			left_q     <= '0;
			in_value_q <= 1'b0;
			match_q    <= 1'b0;
			decided_q  <= 1'b0;
			dstat_q    <= ST_FOUND;
		end else if (take) begin
			if (item.is_last) begin
				phase_q    <= '0;
				type_q     <= '0;
				len_q      <= '0;
				left_q     <= '0;
				in_value_q <= 1'b0;
				match_q    <= 1'b0;
				decided_q  <= 1'b0;
				dstat_q    <= ST_FOUND;
			end else begin
				phase_q    <= n_phase;
				type_q     <= n_type;
				len_q      <= n_len;
				left_q     <= n_left;
				in_value_q <= n_in_value;
				match_q    <= n_match;
				decided_q  <= n_decided;
				dstat_q    <= n_dstat;
			end
		end
	end

	always_comb begin
		tok.data_byte = item.data_byte;
		tok.shift_en  = shift_en;
		tok.clear_en  = clear_en;
		tok.is_last   = item.is_last;
		tok.status    = status;
	end

endmodule

>>> rtl/core/tsfs_tok_fifo.sv
// ----------------------------------------------------------------------------
// TLV stream field search: token queue
// Two-entry queue that decouples the header parser from the value assembler.
// ----------------------------------------------------------------------------
module tsfs_tok_fifo (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             wr_en,
	input  tsfs_pkg::token_t wr_tok,
	output logic             full,
	input  logic             rd_en,
	output tsfs_pkg::token_t rd_tok,
	output logic             empty
);
	import tsfs_pkg::*;

	token_t     mem_q [2];
	logic       wr_ptr_q;
	logic       rd_ptr_q;
	logic [1:0] count_q;

	assign full   = (count_q == 2'd2);
	assign empty  = (count_q == 2'd0);
	assign rd_tok = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_ptr_q] <= wr_tok;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= '0;
		end else begin
			if (wr_en) begin
				wr_ptr_q <= ~wr_ptr_q;
			end
			if (rd_en) begin
				rd_ptr_q <= ~rd_ptr_q;
			end
			if (wr_en && !rd_en) begin
				count_q <= count_q + 2'd1;
			end else if (rd_en && !wr_en) begin
				count_q <= count_q - 2'd1;
			end
		end
	end

endmodule

>>> rtl/core/tsfs_back.sv
// ----------------------------------------------------------------------------
// TLV stream field search: value assembler
// Shifts matched value bytes into a 64-bit word and registers one result
// per buffer on the beat that carries the last byte.
// ----------------------------------------------------------------------------
module tsfs_back (
	input  logic              clk,
	input  logic              arst_n,
	input  tsfs_pkg::token_t  tok,
	input  logic              tok_valid,
	output logic              tok_take,
	output tsfs_pkg::out_item_t result,
	output logic              empty,
	input  logic              pop
);
	import tsfs_pkg::*;

	logic [63:0] value_q;
	logic [63:0] value_next;
	out_item_t   res_q;
	logic        res_valid_q;

	// A last token needs the result register, which frees up on a pop.
	assign tok_take = tok_valid && (!tok.is_last || !res_valid_q || pop);

	always_comb begin
		if (tok.clear_en) begin
			value_next = '0;
		end else if (tok.shift_en) begin
			value_next = {value_q[55:0], tok.data_byte};
		end else begin
			value_next = value_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			value_q     <= '0;
			res_valid_q <= 1'b0;
		end else begin
			if (tok_take) begin
				value_q <= tok.is_last ? 64'd0 : value_next;
			end
			if (tok_take && tok.is_last) begin
				res_valid_q <= 1'b1;
			end else if (pop) begin
				res_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (tok_take && tok.is_last) begin
			res_q.status <= tok.status;
			res_q.value  <= (tok.status == ST_FOUND) ? value_next : 64'd0;
		end
	end

	assign result = res_q;
	assign empty  = !res_valid_q;

endmodule

>>> rtl/core/tlv_stream_field_search.sv
// ----------------------------------------------------------------------------
// TLV stream field search
// Finds the first element of the configured type in a byte stream and
// reports its status and big-endian value once per buffer.
// ----------------------------------------------------------------------------
// Throughput: one byte per cycle while the token queue is not full; the parser
// classifies each byte in the cycle it is accepted.
// The result is registered when the last byte's token leaves the token queue.
// The two-entry token queue lets input continue while a result waits.
// Reset clears both registers to zero, the parse state, queue and result.
module tlv_stream_field_search (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                push,
	output logic                full,
	input  tsfs_pkg::in_item_t  item,
	output logic                empty,
	input  logic                pop,
	output tsfs_pkg::out_item_t result,
	input  logic                cfg_wr_en,
	input  tsfs_pkg::reg_idx_t  cfg_idx,
	input  logic [tsfs_pkg::CFG_W-1:0] cfg_data
);
	import tsfs_pkg::*;

	token_t front_tok;
	token_t back_tok;
	logic   fifo_full;
	logic   fifo_empty;
	logic   tok_take;
	logic   take;

	assign full = fifo_full;
	assign take = push && !fifo_full;

	tsfs_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_wr_en (cfg_wr_en),
		.cfg_idx   (cfg_idx),
		.cfg_data  (cfg_data),
		.take      (take),
		.item      (item),
		.tok       (front_tok)
	);

	tsfs_tok_fifo u_fifo (
		.clk    (clk),
		.arst_n (arst_n),
		.wr_en  (take),
		.wr_tok (front_tok),
		.full   (fifo_full),
		.rd_en  (tok_take),
		.rd_tok (back_tok),
		.empty  (fifo_empty)
	);

	tsfs_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.tok       (back_tok),
		.tok_valid (!fifo_empty),
		.tok_take  (tok_take),
		.result    (result),
		.empty     (empty),
		.pop       (pop)
	);

endmodule
